@@ src/aapr_pkg.sv @@
// Package for the axis-angle point rotation block: widths, pipeline payload
// types, register indexes and the CORDIC arctangent table. No dependencies.
`default_nettype none
package aapr_pkg;

  localparam int STEPS = 16;

  // CORDIC datapath word, signed Q2.30 with headroom
  typedef logic signed [33:0] cval_t;

  localparam cval_t CORDIC_GAIN = 34'sd652032874;
  localparam cval_t ONE_Q30     = 34'sd1073741824;

  // point minus origin, exact
  typedef logic signed [32:0] diff_t;
  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t dz;
  } delta_t;

  // one CORDIC stage
  typedef struct packed {
    cval_t      x;
    cval_t      y;
    cval_t      z;
    logic       zero;
    logic [1:0] q;
  } cstate_t;

  typedef logic signed [16:0] wval_t;
  typedef logic signed [33:0] w2val_t;

  // result of one point
  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic        clipped;
  } res_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_AXIS_X   = 3'd3,
    REG_AXIS_Y   = 3'd4,
    REG_AXIS_Z   = 3'd5
  } reg_idx_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_lut(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0:  v = 32'd536870912;
      4'd1:  v = 32'd316933406;
      4'd2:  v = 32'd167458907;
      4'd3:  v = 32'd85004756;
      4'd4:  v = 32'd42667331;
      4'd5:  v = 32'd21354465;
      4'd6:  v = 32'd10679838;
      4'd7:  v = 32'd5340245;
      4'd8:  v = 32'd2670163;
      4'd9:  v = 32'd1335087;
      4'd10: v = 32'd667544;
      4'd11: v = 32'd333772;
      4'd12: v = 32'd166886;
      4'd13: v = 32'd83443;
      4'd14: v = 32'd41722;
      4'd15: v = 32'd20861;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ src/aapr_stream_if.sv @@
// Stream interfaces for point requests and rotated results.
// Depends on nothing.
`default_nettype none
interface aapr_pt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] px;
  logic [31:0] py;
  logic [31:0] pz;
  logic [15:0] turn;
  modport source (output valid, px, py, pz, turn, input ready);
  modport sink   (input valid, px, py, pz, turn, output ready);
endinterface

interface aapr_pt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rx;
  logic [31:0] ry;
  logic [31:0] rz;
  logic        clipped;
  modport source (output valid, rx, ry, rz, clipped, input ready);
  modport sink   (input valid, rx, ry, rz, clipped, output ready);
endinterface
`default_nettype wire

@@ src/aapr_cordic.sv @@
// Pipelined sine/cosine: quarter-turn fold, 16 CORDIC stages, quadrant fix.
// Carries the point offset alongside. Depends on aapr_pkg.
`default_nettype none
module aapr_cordic (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  wire  [15:0]         turn,
  input  aapr_pkg::delta_t    in_delta,
  output logic                out_valid,
  output aapr_pkg::cval_t     sn,
  output aapr_pkg::cval_t     omc,
  output aapr_pkg::delta_t    out_delta
);

  aapr_pkg::cstate_t st  [aapr_pkg::STEPS+1];
  aapr_pkg::delta_t  dl  [aapr_pkg::STEPS+1];
  logic              vld [aapr_pkg::STEPS+1];

  logic [15:0]        qsum;
  logic [1:0]         q0;
  logic [15:0]        res;
  logic signed [15:0] res_s;

  // fold the angle into one quarter turn
  assign qsum  = turn + 16'h2000;
  assign q0    = qsum[15:14];
  assign res   = turn - {q0, 14'd0};
  assign res_s = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].x    <= aapr_pkg::CORDIC_GAIN;
      st[0].y    <= '0;
      st[0].z    <= aapr_pkg::cval_t'({{2{res_s[15]}}, res_s, 16'd0});
      st[0].zero <= (res == 16'd0);
      st[0].q    <= q0;
      dl[0]      <= in_delta;
    end
  end

  // one micro-rotation per stage
  for (genvar g = 0; g < aapr_pkg::STEPS; g++) begin : g_step
    aapr_pkg::cval_t xi, yi, zi, dx, dy, at;
    assign xi = st[g].x;
    assign yi = st[g].y;
    assign zi = st[g].z;
    assign dx = yi >>> g;
    assign dy = xi >>> g;
    assign at = aapr_pkg::cval_t'({2'b00, aapr_pkg::atan_lut(4'(g))});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[33]) begin
          st[g+1].x <= xi - dx;
          st[g+1].y <= yi + dy;
          st[g+1].z <= zi - at;
        end else begin
          st[g+1].x <= xi + dx;
          st[g+1].y <= yi - dy;
          st[g+1].z <= zi + at;
        end
        st[g+1].zero <= st[g].zero;
        st[g+1].q    <= st[g].q;
        dl[g+1]      <= dl[g];
      end
    end
  end

  // exact quarter turns, then rotate by quadrant
  aapr_pkg::cval_t xf, yf, cs_c, sn_c;
  assign xf = st[aapr_pkg::STEPS].zero ? aapr_pkg::ONE_Q30 : st[aapr_pkg::STEPS].x;
  assign yf = st[aapr_pkg::STEPS].zero ? '0 : st[aapr_pkg::STEPS].y;

  always_comb begin
    case (st[aapr_pkg::STEPS].q)
      2'd0:    begin cs_c = xf;  sn_c = yf;  end
      2'd1:    begin cs_c = -yf; sn_c = xf;  end
      2'd2:    begin cs_c = -xf; sn_c = -yf; end
      default: begin cs_c = yf;  sn_c = -xf; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[aapr_pkg::STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn        <= sn_c;
      omc       <= aapr_pkg::ONE_Q30 - cs_c;
      out_delta <= dl[aapr_pkg::STEPS];
    end
  end

endmodule
`default_nettype wire

@@ src/aapr_xform.sv @@
// Matrix build and point transform: products, matrix rounding, matrix times
// offset, final rounding with origin add and saturation. Depends on aapr_pkg.
`default_nettype none
module aapr_xform (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  aapr_pkg::cval_t     sn,
  input  aapr_pkg::cval_t     omc,
  input  aapr_pkg::delta_t    delta,
  input  wire signed [15:0]   axis_x,
  input  wire signed [15:0]   axis_y,
  input  wire signed [15:0]   axis_z,
  input  aapr_pkg::w2val_t    w2 [3][3],
  input  wire signed [31:0]   org [3],
  output logic                out_valid,
  output aapr_pkg::res_t      res
);

  aapr_pkg::wval_t   wm [3][3];
  logic signed [50:0] p1 [3][3];
  logic signed [67:0] p2 [3][3];
  logic signed [35:0] m  [3][3];
  logic signed [68:0] pr [3][3];
  aapr_pkg::delta_t  dl_a, dl_b;
  logic              vld_a, vld_b, vld_c;
  aapr_pkg::diff_t   dv [3];

  // cross-product matrix of the axis
  always_comb begin
    wm[0][0] = '0;               wm[0][1] = -17'(axis_z);     wm[0][2] = 17'(axis_y);
    wm[1][0] = 17'(axis_z);      wm[1][1] = '0;               wm[1][2] = -17'(axis_x);
    wm[2][0] = -17'(axis_y);     wm[2][1] = 17'(axis_x);      wm[2][2] = '0;
  end

  assign dv[0] = dl_b.dx;
  assign dv[1] = dl_b.dy;
  assign dv[2] = dl_b.dz;

  // advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      vld_b     <= 1'b0;
      vld_c     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_valid;
      vld_b     <= vld_a;
      vld_c     <= vld_b;
      out_valid <= vld_c;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    logic signed [70:0] acc;
    logic signed [46:0] rr;
    logic signed [47:0] rs;

    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [69:0] t;
      logic signed [69:0] tr;
      assign t = ((i == j) ? (70'sd1 <<< 58) : 70'sd0)
               + (70'(p1[i][j]) <<< 14) + 70'(p2[i][j]);
      assign tr = (t + (70'sd1 <<< 33)) >>> 34;

      always_ff @(posedge clk) begin
        if (en) begin
          p1[i][j] <= 51'(sn) * 51'(wm[i][j]);
          p2[i][j] <= 68'(omc) * 68'(w2[i][j]);
          m[i][j]  <= tr[35:0];
          pr[i][j] <= 69'(m[i][j]) * 69'(dv[j]);
        end
      end
    end

    // sum the row, round and move back to the origin
    assign acc = 71'(pr[i][0]) + 71'(pr[i][1]) + 71'(pr[i][2]);
    assign rr  = 47'((acc + (71'sd1 <<< 23)) >>> 24);
    assign rs  = 48'(rr) + 48'(org[i]);
  end

  logic [31:0] sat [3];
  logic [2:0]  clip;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sat[k]  = 32'(g_row[0].rs);
      clip[k] = 1'b0;
    end
    // saturate each coordinate
    if (g_row[0].rs > 48'sh7FFFFFFF) begin
      sat[0] = 32'h7FFFFFFF; clip[0] = 1'b1;
    end else if (g_row[0].rs < -48'sh80000000) begin
      sat[0] = 32'h80000000; clip[0] = 1'b1;
    end else begin
      sat[0] = g_row[0].rs[31:0];
    end
    if (g_row[1].rs > 48'sh7FFFFFFF) begin
      sat[1] = 32'h7FFFFFFF; clip[1] = 1'b1;
    end else if (g_row[1].rs < -48'sh80000000) begin
      sat[1] = 32'h80000000; clip[1] = 1'b1;
    end else begin
      sat[1] = g_row[1].rs[31:0];
    end
    if (g_row[2].rs > 48'sh7FFFFFFF) begin
      sat[2] = 32'h7FFFFFFF; clip[2] = 1'b1;
    end else if (g_row[2].rs < -48'sh80000000) begin
      sat[2] = 32'h80000000; clip[2] = 1'b1;
    end else begin
      sat[2] = g_row[2].rs[31:0];
    end
  end

  // carry the offset along and register the result
  always_ff @(posedge clk) begin
    if (en) begin
      dl_a        <= delta;
      dl_b        <= dl_a;
      res.rx      <= sat[0];
      res.ry      <= sat[1];
      res.rz      <= sat[2];
      res.clipped <= |clip;
    end
  end

endmodule
`default_nettype wire

@@ src/axis_angle_point_rotation.sv @@
// Axis-angle point rotation, top level: configuration registers, offset from
// the origin, CORDIC and transform pipelines. Depends on aapr_pkg, the stream
// interfaces, aapr_cordic and aapr_xform.
//
// Rotates each point about the configured axis through the configured origin
// by turn/65536 of a full turn. One point is taken every clock cycle while
// the output is not stalled; each result passes through the 16-stage CORDIC
// plus fold and quadrant stages and the four transform stages
// (products, matrix rounding, matrix times offset, final rounding and
// saturation). A stall at the output holds the whole pipeline, and the input
// is held off for as long as a result waits. Configuration writes apply to
// requests taken from the next clock edge on and are meant for idle periods.
`default_nettype none
module axis_angle_point_rotation (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_index,
  input  wire  [31:0]          cfg_data,
  aapr_pt_in_if.sink           pin,
  aapr_pt_out_if.source        pout
);

  logic signed [31:0] org [3];
  logic signed [15:0] axis_x, axis_y, axis_z;
  aapr_pkg::w2val_t   w2 [3][3];
  logic               en;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      axis_x <= '0;
      axis_y <= '0;
      axis_z <= 16'sd16384;
    end else if (cfg_we) begin
      case (aapr_pkg::reg_idx_t'(cfg_index))
        aapr_pkg::REG_ORIGIN_X: org[0] <= cfg_data;
        aapr_pkg::REG_ORIGIN_Y: org[1] <= cfg_data;
        aapr_pkg::REG_ORIGIN_Z: org[2] <= cfg_data;
        aapr_pkg::REG_AXIS_X:   axis_x <= cfg_data[15:0];
        aapr_pkg::REG_AXIS_Y:   axis_y <= cfg_data[15:0];
        aapr_pkg::REG_AXIS_Z:   axis_z <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // square of the cross-product matrix: a*a^T - |a|^2 I
  aapr_pkg::w2val_t ax, ay, az;
  assign ax = 34'(axis_x);
  assign ay = 34'(axis_y);
  assign az = 34'(axis_z);

  always_ff @(posedge clk) begin
    w2[0][0] <= -(ay * ay + az * az);
    w2[1][1] <= -(ax * ax + az * az);
    w2[2][2] <= -(ax * ax + ay * ay);
    w2[0][1] <= ax * ay;
    w2[1][0] <= ax * ay;
    w2[0][2] <= ax * az;
    w2[2][0] <= ax * az;
    w2[1][2] <= ay * az;
    w2[2][1] <= ay * az;
  end

  // hold the pipeline only while a result waits unclaimed
  assign en        = !pout.valid || pout.ready;
  assign pin.ready = en;

  aapr_pkg::delta_t in_delta;
  assign in_delta.dx = 33'(signed'(pin.px)) - 33'(org[0]);
  assign in_delta.dy = 33'(signed'(pin.py)) - 33'(org[1]);
  assign in_delta.dz = 33'(signed'(pin.pz)) - 33'(org[2]);

  logic             c_valid;
  aapr_pkg::cval_t  c_sn, c_omc;
  aapr_pkg::delta_t c_delta;

  aapr_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pin.valid),
    .turn      (pin.turn),
    .in_delta  (in_delta),
    .out_valid (c_valid),
    .sn        (c_sn),
    .omc       (c_omc),
    .out_delta (c_delta)
  );

  aapr_pkg::res_t res;

  aapr_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .sn        (c_sn),
    .omc       (c_omc),
    .delta     (c_delta),
    .axis_x    (axis_x),
    .axis_y    (axis_y),
    .axis_z    (axis_z),
    .w2        (w2),
    .org       (org),
    .out_valid (pout.valid),
    .res       (res)
  );

  assign pout.rx      = res.rx;
  assign pout.ry      = res.ry;
  assign pout.rz      = res.rz;
  assign pout.clipped = res.clipped;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for axis_angle_point_rotation: directed and random
// point requests, checked against a bit-exact rotation predictor.
// Depends on aapr_pkg, the stream interfaces and the block itself.
`default_nettype none
module tb_top;

  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;
  localparam int IDLE_CYCLES = 40;
  localparam longint GAIN_Q30 = 64'd652032874;
  localparam longint UNIT_Q30 = 64'd1073741824;
  localparam longint ATAN_TURN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_index = '0;
  logic [31:0]     cfg_data = '0;
  int              errors = 0;
  aapr_pkg::res_t  pending_points[$];

  // predictor copy of the registers
  longint centre [3];
  longint axis [3];

  aapr_pt_in_if  pin_if ();
  aapr_pt_out_if pout_if ();

  axis_angle_point_rotation i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pin       (pin_if.sink),
    .pout      (pout_if.source)
  );

  always #4 clk = ~clk;

  initial begin
    pin_if.valid = 1'b0;
    pin_if.px = '0;
    pin_if.py = '0;
    pin_if.pz = '0;
    pin_if.turn = '0;
    pout_if.ready = 1'b0;
  end

  // sine and cosine in Q2.30 from the folded angle and a 16-step CORDIC
  function automatic void turn_sin_cos(input logic [15:0] turn, output longint sn,
                                       output longint cs);
    logic [1:0]         q;
    logic signed [15:0] resid;
    longint             x, y, z, dx, dy;
    q = 2'(({1'b0, turn} + 17'd8192) >> 14);
    resid = turn - (16'(q) << 14);
    if (resid == 0) begin
      x = UNIT_Q30;
      y = 0;
    end else begin
      x = GAIN_Q30;
      y = 0;
      z = longint'(resid) * 65536;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_TURN[i];
        end else begin
          x += dx; y -= dy; z += ATAN_TURN[i];
        end
      end
    end
    case (q)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  // rotated point for the current register settings
  function automatic aapr_pkg::res_t rotated_point(logic [31:0] px, logic [31:0] py,
                                                   logic [31:0] pz, logic [15:0] turn);
    longint w [3][3];
    longint w2 [3][3];
    longint m [3][3];
    longint d [3];
    longint sn, cs, omc, t, acc, r;
    logic [31:0] coord [3];
    logic clip;
    aapr_pkg::res_t res;
    clip = 1'b0;
    w[0][0] = 0;        w[0][1] = -axis[2]; w[0][2] = axis[1];
    w[1][0] = axis[2];  w[1][1] = 0;        w[1][2] = -axis[0];
    w[2][0] = -axis[1]; w[2][1] = axis[0];  w[2][2] = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        w2[i][j] = 0;
        for (int k = 0; k < 3; k++) w2[i][j] += w[i][k] * w[k][j];
      end
    turn_sin_cos(turn, sn, cs);
    omc = UNIT_Q30 - cs;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        t = (i == j) ? (longint'(1) << 58) : 0;
        t += sn * w[i][j] * 16384;
        t += omc * w2[i][j];
        m[i][j] = (t + (longint'(1) << 33)) >>> 34;
      end
    d[0] = longint'($signed(px)) - centre[0];
    d[1] = longint'($signed(py)) - centre[1];
    d[2] = longint'($signed(pz)) - centre[2];
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += m[i][j] * d[j];
      r = ((acc + (longint'(1) << 23)) >>> 24) + centre[i];
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647; clip = 1'b1;
      end
      if (r < -64'sd2147483648) begin
        r = -64'sd2147483648; clip = 1'b1;
      end
      coord[i] = r[31:0];
    end
    res.rx = coord[0];
    res.ry = coord[1];
    res.rz = coord[2];
    res.clipped = clip;
    return res;
  endfunction

  // hold until the pipeline has drained
  task automatic wait_drained();
    wait (pending_points.size() == 0);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      aapr_pkg::REG_ORIGIN_X: centre[0] = longint'($signed(value));
      aapr_pkg::REG_ORIGIN_Y: centre[1] = longint'($signed(value));
      aapr_pkg::REG_ORIGIN_Z: centre[2] = longint'($signed(value));
      aapr_pkg::REG_AXIS_X:   axis[0] = longint'($signed(value[15:0]));
      aapr_pkg::REG_AXIS_Y:   axis[1] = longint'($signed(value[15:0]));
      aapr_pkg::REG_AXIS_Z:   axis[2] = longint'($signed(value[15:0]));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] oz, input logic [15:0] ax,
                           input logic [15:0] ay, input logic [15:0] az);
    wait_drained();
    write_reg(aapr_pkg::REG_ORIGIN_X, ox);
    write_reg(aapr_pkg::REG_ORIGIN_Y, oy);
    write_reg(aapr_pkg::REG_ORIGIN_Z, oz);
    write_reg(aapr_pkg::REG_AXIS_X, {{16{ax[15]}}, ax});
    write_reg(aapr_pkg::REG_AXIS_Y, {{16{ay[15]}}, ay});
    write_reg(aapr_pkg::REG_AXIS_Z, {{16{az[15]}}, az});
    repeat (4) @(posedge clk);
  endtask

  // send one point request after a random gap
  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [15:0] turn);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      pin_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin_if.valid <= 1'b1;
    pin_if.px <= px;
    pin_if.py <= py;
    pin_if.pz <= pz;
    pin_if.turn <= turn;
    do @(posedge clk); while (!pin_if.ready);
    pending_points.push_back(rotated_point(px, py, pz, turn));
  endtask

  // drop valid straight after the last accepted request
  task automatic end_burst();
    pin_if.valid <= 1'b0;
  endtask

  // compare each result with the oldest expectation
  initial begin
    int             stall;
    aapr_pkg::res_t want;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        pout_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pout_if.ready <= 1'b1;
      do @(posedge clk); while (!pout_if.valid);
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result rx=%h ry=%h rz=%h clipped=%b", $time,
                 pout_if.rx, pout_if.ry, pout_if.rz, pout_if.clipped);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (pout_if.rx !== want.rx) begin
          $display("%0t: rx expected %h actual %h", $time, want.rx, pout_if.rx);
          errors++;
        end
        if (pout_if.ry !== want.ry) begin
          $display("%0t: ry expected %h actual %h", $time, want.ry, pout_if.ry);
          errors++;
        end
        if (pout_if.rz !== want.rz) begin
          $display("%0t: rz expected %h actual %h", $time, want.rz, pout_if.rz);
          errors++;
        end
        if (pout_if.clipped !== want.clipped) begin
          $display("%0t: clipped expected %b actual %b", $time, want.clipped,
                   pout_if.clipped);
          errors++;
        end
      end
    end
  end

  // quarter turns, fold boundaries and wrap of the angle
  task automatic test_turn_folding();
    logic [15:0] turns [10] = '{16'd0, 16'd1, 16'd8191, 16'd8192, 16'd16384,
                                16'd24575, 16'd32768, 16'd49152, 16'd57344,
                                16'd65535};
    foreach (turns[i]) send_point(32'h0003_8000, 32'hFFFE_4000, 32'h0001_0000,
                                  turns[i]);
    end_burst();
  endtask

  // field extremes, saturation and oversized axes
  task automatic test_extremes();
    set_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
              16'h4000, 16'hC000, 16'h4000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd12000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd40000);
    send_point(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 16'd0);
    end_burst();
    set_frame(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
              16'h8000, 16'h7FFF, 16'h8000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd65535);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd20000);
    send_point(32'h0010_0000, 32'hFFF0_0000, 32'h0000_0000, 16'd4096);
    end_burst();
  endtask

  // unused register indexes must leave the frame alone
  task automatic test_spare_indexes();
    set_frame(32'h0002_0000, 32'h0, 32'h0, 16'h0, 16'h4000, 16'h0);
    write_reg(IDX_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(IDX_SPARE_HI, 32'h1234_5678);
    repeat (4) @(posedge clk);
    send_point(32'h0005_0000, 32'h0001_0000, 32'hFFFD_0000, 16'd16384);
    send_point(32'h0005_0000, 32'h0001_0000, 32'hFFFD_0000, 16'd5461);
    end_burst();
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 4))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'($urandom());
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // random points under a series of random frames
  task automatic test_random_points();
    logic [15:0] turn;
    for (int phase = 0; phase < 11; phase++) begin
      if (phase > 0) set_frame(rand_coord(), rand_coord(), rand_coord(),
                               rand_axis(), rand_axis(), rand_axis());
      for (int n = 0; n < 50; n++) begin
        turn = ($urandom_range(0, 7) == 0) ? 16'(($urandom_range(0, 3)) << 14)
                                           : 16'($urandom());
        send_point(rand_coord(), rand_coord(), rand_coord(), turn);
        if (n == 25 && phase % 3 == 0) begin
          pin_if.valid <= 1'b0;
          wait (pending_points.size() == 0);
          @(posedge clk);
        end
      end
      end_burst();
    end
  endtask

  initial begin
    centre = '{0, 0, 0};
    axis = '{0, 0, 16384};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_turn_folding();
    test_extremes();
    test_spare_indexes();
    test_random_points();
    wait_drained();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #(8 * 2000000);
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
